// ===== rtl/tosu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosu_pkg: shared types and constants of the typed operand stack unit
// Function and status codes, slot type codes, the slot descriptor and the
// control word that is broadcast to every cell of the stack.
// ----------------------------------------------------------------------------
package tosu_pkg;

  localparam int DEF_MAX_DEPTH = 32;
  localparam int DEF_TAG_BITS  = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
  // register index is paddr[2]
  localparam logic REG_STACK_LIMIT = 1'b0;

  localparam logic [2:0] PTY_I64  = 3'd1;
  localparam logic [2:0] PTY_F64  = 3'd3;
  localparam logic [2:0] TYPE_MAX = 3'd6;

  typedef enum logic [3:0] {
    FN_PUSH      = 4'd0,
    FN_POP_TYPED = 4'd1,
    FN_POP_WIDTH = 4'd2,
    FN_POP_AUTO  = 4'd3,
    FN_POP       = 4'd4,
    FN_POP2      = 4'd5,
    FN_DUP       = 4'd6,
    FN_DUP_X1    = 4'd7,
    FN_DUP_X2    = 4'd8,
    FN_DUP2      = 4'd9,
    FN_DUP2_X1   = 4'd10,
    FN_DUP2_X2   = 4'd11,
    FN_SWAP      = 4'd12
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_UP1,
    CM_UP2,
    CM_INSERT,
    CM_WRITE2
  } cell_mode_e;

  typedef struct packed {
    logic [2:0] vtype;
    logic       dummy;
  } meta_t;

  typedef struct packed {
    cell_mode_e mode;
    logic [2:0] ins_pos;
    logic       ins_two;
  } cell_ctrl_t;

  function automatic logic wide_type(input logic [2:0] t);
    return (t == PTY_I64) || (t == PTY_F64);
  endfunction

endpackage

// ===== rtl/tosu_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosu_cell: one slot of the operand stack
// Holds the slot at a fixed depth below the top and loads from its upper or
// lower neighbors, or from the broadcast source slots, as the control says.
// ----------------------------------------------------------------------------
module tosu_cell #(
  parameter int Idx     = 0,
  parameter int TagBits = tosu_pkg::DEF_TAG_BITS
) (
  input  logic                          clk_i,
  input  tosu_pkg::cell_ctrl_t          ctrl_i,
  input  logic [1:0][TagBits-1:0]       src_tag_i,
  input  tosu_pkg::meta_t [1:0]         src_meta_i,
  input  logic [TagBits-1:0]            up1_tag_i,
  input  tosu_pkg::meta_t               up1_meta_i,
  input  logic [TagBits-1:0]            up2_tag_i,
  input  tosu_pkg::meta_t               up2_meta_i,
  input  logic [TagBits-1:0]            dn1_tag_i,
  input  tosu_pkg::meta_t               dn1_meta_i,
  input  logic [TagBits-1:0]            dn2_tag_i,
  input  tosu_pkg::meta_t               dn2_meta_i,
  output logic [TagBits-1:0]            tag_o,
  output tosu_pkg::meta_t               meta_o
);
  import tosu_pkg::*;

  logic [TagBits-1:0] tag_q, tag_d;
  meta_t              meta_q, meta_d;

  always_comb begin
    int ins_lo;
    int ins_hi;
    ins_lo = int'(ctrl_i.ins_pos);
    ins_hi = ins_lo + (ctrl_i.ins_two ? 2 : 1);
    tag_d  = tag_q;
    meta_d = meta_q;
    case (ctrl_i.mode)
      CM_UP1: begin
        tag_d  = dn1_tag_i;
        meta_d = dn1_meta_i;
      end
      CM_UP2: begin
        tag_d  = dn2_tag_i;
        meta_d = dn2_meta_i;
      end
      CM_INSERT: begin
        // cells above the insert point keep, the new slots land, the rest move down
        if (Idx < ins_lo) begin
          tag_d  = tag_q;
          meta_d = meta_q;
        end else if (Idx < ins_hi) begin
          if (Idx == ins_lo) begin
            tag_d  = src_tag_i[0];
            meta_d = src_meta_i[0];
          end else begin
            tag_d  = src_tag_i[1];
            meta_d = src_meta_i[1];
          end
        end else if (ctrl_i.ins_two) begin
          tag_d  = up2_tag_i;
          meta_d = up2_meta_i;
        end else begin
          tag_d  = up1_tag_i;
          meta_d = up1_meta_i;
        end
      end
      CM_WRITE2: begin
        if (Idx == 0) begin
          tag_d  = src_tag_i[0];
          meta_d = src_meta_i[0];
        end else if (Idx == 1) begin
          tag_d  = src_tag_i[1];
          meta_d = src_meta_i[1];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_d;
    meta_q <= meta_d;
  end

  assign tag_o  = tag_q;
  assign meta_o = meta_q;

endmodule

// ===== rtl/tosu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosu_ctrl: operation decode and checks
// Checks depth and room against the slot count, slot layout against the top
// four slots, keeps the count and drives the cell row's control word and source slots.
// ----------------------------------------------------------------------------
module tosu_ctrl #(
  parameter int MaxDepth = tosu_pkg::DEF_MAX_DEPTH,
  parameter int TagBits  = tosu_pkg::DEF_TAG_BITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [3:0]                        func_i,
  input  logic [TagBits-1:0]                push_tag_i,
  input  logic [2:0]                        value_type_i,
  input  logic                              want_wide_i,
  input  logic [tosu_pkg::LIMIT_W-1:0]      stack_limit_i,
  input  tosu_pkg::meta_t [3:0]             top_meta_i,
  input  logic [1:0][TagBits-1:0]           top_tag_i,
  output tosu_pkg::status_e                 status_o,
  output tosu_pkg::cell_ctrl_t              ctrl_o,
  output logic [1:0][TagBits-1:0]           src_tag_o,
  output tosu_pkg::meta_t [1:0]             src_meta_o
);
  import tosu_pkg::*;

  localparam int CntW = $clog2(MaxDepth + 1);
  localparam int LimW = (CntW > LIMIT_W) ? CntW : LIMIT_W;

  logic [CntW-1:0] count_q, count_d;
  logic [LimW:0]   lim, cnt_w;
  logic            room1, room2;
  logic [3:0]      nm, dm, wd;

  always_comb begin
    lim = (LimW + 1)'(stack_limit_i);
    if (lim > (LimW + 1)'(MaxDepth)) begin
      lim = (LimW + 1)'(MaxDepth);
    end
    cnt_w = (LimW + 1)'(count_q);
    room1 = (cnt_w + (LimW + 1)'(1)) <= lim;
    room2 = (cnt_w + (LimW + 1)'(2)) <= lim;
  end

  for (genvar k = 0; k < 4; k++) begin : g_cls
    assign dm[k] = top_meta_i[k].dummy;
    assign wd[k] = !top_meta_i[k].dummy && wide_type(top_meta_i[k].vtype);
    assign nm[k] = !top_meta_i[k].dummy && !wide_type(top_meta_i[k].vtype);
  end

  always_comb begin
    status_e    st;
    cell_ctrl_t c;
    logic [1:0] grow, shrink;
    logic       vw, top_ok, low_ok;
    st        = ST_OK;
    c.mode    = CM_HOLD;
    c.ins_pos = 3'd0;
    c.ins_two = 1'b0;
    grow      = 2'd0;
    shrink    = 2'd0;
    vw        = wide_type(value_type_i);
    top_ok    = (nm[0] && nm[1]) || (dm[0] && wd[1]);
    low_ok    = (nm[2] && nm[3]) || (dm[2] && wd[3]);
    src_tag_o[0]  = top_tag_i[0];
    src_tag_o[1]  = top_tag_i[1];
    src_meta_o[0] = top_meta_i[0];
    src_meta_o[1] = top_meta_i[1];

    unique case (func_i)
      FN_PUSH: begin
        // a wide value goes in as head plus a dummy slot on top
        src_tag_o[1]  = push_tag_i;
        src_meta_o[1] = '{vtype: value_type_i, dummy: 1'b0};
        src_tag_o[0]  = vw ? '0 : push_tag_i;
        src_meta_o[0] = '{vtype: value_type_i, dummy: vw};
        if (value_type_i > TYPE_MAX) st = ST_BAD;
        else if (vw ? !room2 : !room1) st = ST_FULL;
        else begin
          c.mode    = CM_INSERT;
          c.ins_two = vw;
          grow      = vw ? 2'd2 : 2'd1;
        end
      end
      FN_POP_TYPED: begin
        if (value_type_i > TYPE_MAX) st = ST_BAD;
        else if (vw) begin
          if (count_q < CntW'(2)) st = ST_FEW;
          else if (!(dm[0] && wd[1] && top_meta_i[1].vtype == value_type_i)) st = ST_BAD;
          else begin
            c.mode = CM_UP2;
            shrink = 2'd2;
          end
        end else begin
          if (count_q < CntW'(1)) st = ST_FEW;
          else if (!(nm[0] && top_meta_i[0].vtype == value_type_i)) st = ST_BAD;
          else begin
            c.mode = CM_UP1;
            shrink = 2'd1;
          end
        end
      end
      FN_POP_WIDTH: begin
        if (want_wide_i) begin
          if (count_q < CntW'(2)) st = ST_FEW;
          else if (!(dm[0] && wd[1])) st = ST_BAD;
          else begin
            c.mode = CM_UP2;
            shrink = 2'd2;
          end
        end else begin
          if (count_q < CntW'(1)) st = ST_FEW;
          else if (!nm[0]) st = ST_BAD;
          else begin
            c.mode = CM_UP1;
            shrink = 2'd1;
          end
        end
      end
      FN_POP_AUTO: begin
        if (count_q < CntW'(1)) st = ST_FEW;
        else if (dm[0]) begin
          if (count_q < CntW'(2)) st = ST_FEW;
          else if (!wd[1]) st = ST_BAD;
          else begin
            c.mode = CM_UP2;
            shrink = 2'd2;
          end
        end else if (!nm[0]) st = ST_BAD;
        else begin
          c.mode = CM_UP1;
          shrink = 2'd1;
        end
      end
      FN_POP: begin
        if (count_q < CntW'(1)) st = ST_FEW;
        else if (!nm[0]) st = ST_BAD;
        else begin
          c.mode = CM_UP1;
          shrink = 2'd1;
        end
      end
      FN_POP2: begin
        if (count_q < CntW'(2)) st = ST_FEW;
        else if (!top_ok) st = ST_BAD;
        else begin
          c.mode = CM_UP2;
          shrink = 2'd2;
        end
      end
      FN_DUP: begin
        if (count_q < CntW'(1)) st = ST_FEW;
        else if (!nm[0]) st = ST_BAD;
        else if (!room1) st = ST_FULL;
        else begin
          c.mode = CM_INSERT;
          grow   = 2'd1;
        end
      end
      FN_DUP_X1: begin
        if (count_q < CntW'(2)) st = ST_FEW;
        else if (!(nm[0] && nm[1])) st = ST_BAD;
        else if (!room1) st = ST_FULL;
        else begin
          c.mode    = CM_INSERT;
          c.ins_pos = 3'd2;
          grow      = 2'd1;
        end
      end
      FN_DUP_X2: begin
        if (count_q < CntW'(3)) st = ST_FEW;
        else if (!(nm[0] && ((nm[1] && nm[2]) || (dm[1] && wd[2])))) st = ST_BAD;
        else if (!room1) st = ST_FULL;
        else begin
          c.mode    = CM_INSERT;
          c.ins_pos = 3'd3;
          grow      = 2'd1;
        end
      end
      FN_DUP2: begin
        if (count_q < CntW'(2)) st = ST_FEW;
        else if (!top_ok) st = ST_BAD;
        else if (!room2) st = ST_FULL;
        else begin
          c.mode    = CM_INSERT;
          c.ins_two = 1'b1;
          grow      = 2'd2;
        end
      end
      FN_DUP2_X1: begin
        if (count_q < CntW'(3)) st = ST_FEW;
        else if (!(nm[2] && top_ok)) st = ST_BAD;
        else if (!room2) st = ST_FULL;
        else begin
          c.mode    = CM_INSERT;
          c.ins_pos = 3'd3;
          c.ins_two = 1'b1;
          grow      = 2'd2;
        end
      end
      FN_DUP2_X2: begin
        if (count_q < CntW'(4)) st = ST_FEW;
        else if (!(top_ok && low_ok)) st = ST_BAD;
        else if (!room2) st = ST_FULL;
        else begin
          c.mode    = CM_INSERT;
          c.ins_pos = 3'd4;
          c.ins_two = 1'b1;
          grow      = 2'd2;
        end
      end
      FN_SWAP: begin
        src_tag_o[0]  = top_tag_i[1];
        src_tag_o[1]  = top_tag_i[0];
        src_meta_o[0] = top_meta_i[1];
        src_meta_o[1] = top_meta_i[0];
        if (count_q < CntW'(2)) st = ST_FEW;
        else if (!(nm[0] && nm[1])) st = ST_BAD;
        else c.mode = CM_WRITE2;
      end
      default: st = ST_BAD;
    endcase

    if (!accept_i || st != ST_OK) begin
      c.mode = CM_HOLD;
      grow   = 2'd0;
      shrink = 2'd0;
    end
    count_d  = count_q + CntW'(grow) - CntW'(shrink);
    status_o = st;
    ctrl_o   = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/typed_operand_stack_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typed_operand_stack_unit_top: typed operand stack with dup and swap
//
//   channel  | signals                                        | transfer when
//   ---------+------------------------------------------------+---------------------
//   in       | func_i value_tag_i value_type_i want_wide_i    | in_valid_i & in_ready_o
//   out      | status_o                                       | out_valid_o & out_ready_i
//   cfg      | psel penable pwrite paddr pwdata prdata pready | psel & penable & pwrite
//
// one operation per cycle while in_ready_o is high: the whole row of slot cells shifts
// or loads in the cycle of the input transfer, and its status enters the status queue
// a two-entry status queue keeps the input open while a result waits
// reset clears the slot count and sets stack_limit to 32; slots need no clearing
// a stalled output holds the input off only once two results are queued
// ----------------------------------------------------------------------------
module typed_operand_stack_unit_top #(
  parameter int MaxDepth = tosu_pkg::DEF_MAX_DEPTH,
  parameter int TagBits  = tosu_pkg::DEF_TAG_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [3:0]                      func_i,
  input  logic [15:0]                     value_tag_i,
  input  logic [2:0]                      value_type_i,
  input  logic                            want_wide_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tosu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tosu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tosu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tosu_pkg::*;

  logic [LIMIT_W-1:0] stack_limit_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STACK_LIMIT);
  assign prdata = (paddr[2] == REG_STACK_LIMIT) ?
                  {{(CFG_DATA_W - LIMIT_W){1'b0}}, stack_limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_limit_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      stack_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // status queue
  logic [1:0] ocnt_q, ocnt_d, oafter;
  logic [1:0] head_q, head_d, tail_q, tail_d;
  logic       in_xfer, out_xfer;
  status_e    status;

  assign in_ready_o  = (ocnt_q != 2'd2);
  assign out_valid_o = (ocnt_q != 2'd0);
  assign status_o    = head_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_o && out_ready_i;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    oafter = ocnt_q - {1'b0, out_xfer};
    if (out_xfer) begin
      head_d = tail_q;
    end
    if (in_xfer) begin
      if (oafter == 2'd0) begin
        head_d = status;
      end else begin
        tail_d = status;
      end
    end
    ocnt_d = oafter + {1'b0, in_xfer};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= 2'd0;
    end else begin
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  // cell row, padded by two dead slots on each end
  logic [TagBits-1:0]   pad_tag  [MaxDepth+4];
  meta_t                pad_meta [MaxDepth+4];
  logic [TagBits+15:0]  tag_ext;
  logic [TagBits-1:0]   push_tag;
  cell_ctrl_t           cell_ctrl;
  logic [1:0][TagBits-1:0] src_tag, top_tag;
  meta_t [1:0]          src_meta;
  meta_t [3:0]          top_meta;

  assign tag_ext  = {{TagBits{1'b0}}, value_tag_i};
  assign push_tag = tag_ext[TagBits-1:0];

  assign pad_tag[0]           = '0;
  assign pad_tag[1]           = '0;
  assign pad_tag[MaxDepth+2]  = '0;
  assign pad_tag[MaxDepth+3]  = '0;
  assign pad_meta[0]          = '0;
  assign pad_meta[1]          = '0;
  assign pad_meta[MaxDepth+2] = '0;
  assign pad_meta[MaxDepth+3] = '0;

  for (genvar g = 0; g < MaxDepth; g++) begin : g_cell
    tosu_cell #(
      .Idx     (g),
      .TagBits (TagBits)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .src_tag_i  (src_tag),
      .src_meta_i (src_meta),
      .up1_tag_i  (pad_tag[g+1]),
      .up1_meta_i (pad_meta[g+1]),
      .up2_tag_i  (pad_tag[g]),
      .up2_meta_i (pad_meta[g]),
      .dn1_tag_i  (pad_tag[g+3]),
      .dn1_meta_i (pad_meta[g+3]),
      .dn2_tag_i  (pad_tag[g+4]),
      .dn2_meta_i (pad_meta[g+4]),
      .tag_o      (pad_tag[g+2]),
      .meta_o     (pad_meta[g+2])
    );
  end

  assign top_tag[0]  = pad_tag[2];
  assign top_tag[1]  = pad_tag[3];
  assign top_meta[0] = pad_meta[2];
  assign top_meta[1] = pad_meta[3];
  assign top_meta[2] = pad_meta[4];
  assign top_meta[3] = pad_meta[5];

  tosu_ctrl #(
    .MaxDepth (MaxDepth),
    .TagBits  (TagBits)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_xfer),
    .func_i        (func_i),
    .push_tag_i    (push_tag),
    .value_type_i  (value_type_i),
    .want_wide_i   (want_wide_i),
    .stack_limit_i (stack_limit_q),
    .top_meta_i    (top_meta),
    .top_tag_i     (top_tag),
    .status_o      (status),
    .ctrl_o        (cell_ctrl),
    .src_tag_o     (src_tag),
    .src_meta_o    (src_meta)
  );

endmodule

// ===== rtl/tosu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tosu_chk: port-level checks of the typed operand stack unit
// Watches the handshakes and the register port of the top level.
// ----------------------------------------------------------------------------
module tosu_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [3:0]                      func_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [1:0]                      status_o,
  input logic                            psel,
  input logic                            penable,
  input logic                            pwrite,
  input logic [tosu_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [tosu_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [tosu_pkg::CFG_DATA_W-1:0] prdata,
  input logic                            pready
);
  import tosu_pkg::*;

  logic in_xfer, cfg_wr0;

  assign in_xfer = in_valid_i && in_ready_o;
  assign cfg_wr0 = psel && penable && pwrite && pready && (paddr[2] == REG_STACK_LIMIT);

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(status_o)))
    else $error("result dropped or changed while stalled");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !out_valid_o) |=> out_valid_o)
    else $error("no result after transfer into empty queue");

  a_bad_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !out_valid_o && func_i > FN_SWAP) |=> (status_o == ST_BAD))
    else $error("unused function code not rejected");

  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr0 ##1 (psel && paddr[2] == REG_STACK_LIMIT)
      |-> (prdata[LIMIT_W-1:0] == $past(pwdata[LIMIT_W-1:0])))
    else $error("stack_limit readback mismatch");

endmodule

bind typed_operand_stack_unit_top tosu_chk u_tosu_chk (.*);
